FILE: src/elastic_collision_response_2d_core_macros.svh
// ----------------------------------------------------------------------------
// elastic collision response assertion macros
// shared concurrent assertion forms for the collision core
// ----------------------------------------------------------------------------
`ifndef ELASTIC_COLLISION_RESPONSE_2D_CORE_MACROS_SVH
`define ELASTIC_COLLISION_RESPONSE_2D_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define ECR_ASSERT_IMPL(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("collision core check failed");

// next-cycle implication, checked outside reset
`define ECR_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("collision core check failed");

`endif

FILE: src/ecr_pkg.sv
// ----------------------------------------------------------------------------
// ecr_pkg
// shared widths, defaults and item types of the collision core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ecr_pkg;

  localparam int FRAC_BITS_DEF   = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int POS_W  = 32;
  localparam int VEL_W  = 32;
  localparam int MASS_W = 31;
  localparam int DIFF_W = POS_W + 1;
  localparam int MSUM_W = MASS_W + 1;
  localparam int PLO_W  = 32;

  // data that rides along the whole back pipeline
  typedef struct packed {
    logic signed [VEL_W-1:0] v1x;
    logic signed [VEL_W-1:0] v1y;
    logic signed [VEL_W-1:0] v2x;
    logic signed [VEL_W-1:0] v2y;
    logic [MASS_W-1:0]       m1;
    logic [MASS_W-1:0]       m2;
    logic [MSUM_W-1:0]       msum;
    logic                    coin;
    logic                    bypass;
    logic                    nxneg;
    logic                    nyneg;
    logic                    wneg;
  } side_t;

  // classified word as held in the queue
  typedef struct packed {
    logic signed [DIFF_W-1:0] nx;
    logic signed [DIFF_W-1:0] ny;
    logic signed [DIFF_W-1:0] dvx;
    logic signed [DIFF_W-1:0] dvy;
    side_t                    side;
  } item_t;

endpackage

FILE: src/ecr_front.sv
// ----------------------------------------------------------------------------
// ecr_front
// forms centre and velocity differences and classifies each word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ecr_front (
  input  logic signed [ecr_pkg::POS_W-1:0]  first_pos_x,
  input  logic signed [ecr_pkg::POS_W-1:0]  first_pos_y,
  input  logic signed [ecr_pkg::POS_W-1:0]  second_pos_x,
  input  logic signed [ecr_pkg::POS_W-1:0]  second_pos_y,
  input  logic signed [ecr_pkg::VEL_W-1:0]  first_vel_x,
  input  logic signed [ecr_pkg::VEL_W-1:0]  first_vel_y,
  input  logic signed [ecr_pkg::VEL_W-1:0]  second_vel_x,
  input  logic signed [ecr_pkg::VEL_W-1:0]  second_vel_y,
  input  logic [ecr_pkg::MASS_W-1:0]        first_mass,
  input  logic [ecr_pkg::MASS_W-1:0]        second_mass,
  output ecr_pkg::item_t                    item
);

  localparam int DW = ecr_pkg::DIFF_W;
  localparam int SW = ecr_pkg::MSUM_W;

  logic signed [DW-1:0] nx;
  logic signed [DW-1:0] ny;
  logic [SW-1:0]        msum;
  logic                 coin;

  assign nx   = DW'(second_pos_x) - DW'(first_pos_x);
  assign ny   = DW'(second_pos_y) - DW'(first_pos_y);
  assign msum = SW'(first_mass) + SW'(second_mass);
  assign coin = (nx == '0) && (ny == '0);

  always_comb begin
    item.nx          = nx;
    item.ny          = ny;
    item.dvx         = DW'(second_vel_x) - DW'(first_vel_x);
    item.dvy         = DW'(second_vel_y) - DW'(first_vel_y);
    item.side.v1x    = first_vel_x;
    item.side.v1y    = first_vel_y;
    item.side.v2x    = second_vel_x;
    item.side.v2y    = second_vel_y;
    item.side.m1     = first_mass;
    item.side.m2     = second_mass;
    item.side.msum   = msum;
    item.side.coin   = coin;
    // no exchange for coincident centres or a zero mass sum
    item.side.bypass = coin || (msum == '0);
    item.side.nxneg  = nx[DW-1];
    item.side.nyneg  = ny[DW-1];
    item.side.wneg   = 1'b0;
  end

endmodule

FILE: src/ecr_queue.sv
// ----------------------------------------------------------------------------
// ecr_queue
// short flop fifo between the front and the back pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "elastic_collision_response_2d_core_macros.svh"

module ecr_queue #(
  parameter int W     = 8,
  parameter int DEPTH = ecr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         pop_valid,
  output logic [W-1:0] pop_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  assign full      = count == CNT_W'(DEPTH);
  assign pop_valid = count != '0;
  assign pop_data  = mem[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  `ECR_ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(DEPTH))
  `ECR_ASSERT_IMPL(a_no_pop_empty, clk, rst, pop, count != '0)
  `ECR_ASSERT_IMPL(a_no_push_full, clk, rst, push, count != CNT_W'(DEPTH))

endmodule

FILE: src/ecr_div_pipe.sv
// ----------------------------------------------------------------------------
// ecr_div_pipe
// pipelined restoring divider, one quotient bit per stage, shared divisor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ecr_div_pipe #(
  parameter int NUM_W  = 64,
  parameter int DEN_W  = 32,
  parameter int QUO_W  = 34,
  parameter int LANES  = 1,
  parameter int SIDE_W = 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [LANES-1:0][NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]             den,
  input  logic [SIDE_W-1:0]            side_in,
  output logic                         out_valid,
  output logic [LANES-1:0][QUO_W-1:0]  quo,
  output logic [SIDE_W-1:0]            side_out
);

  // low holds the numerator bits still to come, quotient bits enter at the bottom
  logic                         vld [QUO_W+1];
  logic [LANES-1:0][DEN_W-1:0]  rem [QUO_W];
  logic [LANES-1:0][QUO_W-1:0]  low [QUO_W+1];
  logic [DEN_W-1:0]             dvs [QUO_W];
  logic [SIDE_W-1:0]            sd  [QUO_W+1];

  assign vld[0] = in_valid;
  assign dvs[0] = den;
  assign sd[0]  = side_in;

  for (genvar l = 0; l < LANES; l++) begin : g_load
    assign rem[0][l] = DEN_W'(num[l][NUM_W-1:QUO_W]);
    assign low[0][l] = num[l][QUO_W-1:0];
  end

  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    logic [LANES-1:0][QUO_W-1:0] low_n;

    if (s < QUO_W - 1) begin : g_mid
      logic [LANES-1:0][DEN_W-1:0] rem_n;
      for (genvar l = 0; l < LANES; l++) begin : g_lane
        logic [DEN_W:0] trial;
        logic           ge;
        assign trial    = {rem[s][l], low[s][l][QUO_W-1]};
        assign ge       = trial >= {1'b0, dvs[s]};
        assign low_n[l] = {low[s][l][QUO_W-2:0], ge};
        assign rem_n[l] = ge ? DEN_W'(trial - {1'b0, dvs[s]}) : trial[DEN_W-1:0];
      end
      always_ff @(posedge clk) begin
        if (en) begin
          rem[s+1] <= rem_n;
          dvs[s+1] <= dvs[s];
        end
      end
    end else begin : g_last
      for (genvar l = 0; l < LANES; l++) begin : g_lane
        logic [DEN_W:0] trial;
        logic           ge;
        assign trial    = {rem[s][l], low[s][l][QUO_W-1]};
        assign ge       = trial >= {1'b0, dvs[s]};
        assign low_n[l] = {low[s][l][QUO_W-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        low[s+1] <= low_n;
        sd[s+1]  <= sd[s];
      end
    end
  end

  assign out_valid = vld[QUO_W];
  assign quo       = low[QUO_W];
  assign side_out  = sd[QUO_W];

endmodule

FILE: src/ecr_back.sv
// ----------------------------------------------------------------------------
// ecr_back
// projection, mass exchange and saturation pipeline of the collision core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "elastic_collision_response_2d_core_macros.svh"

module ecr_back #(
  parameter int FRAC_BITS = ecr_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             q_valid,
  input  ecr_pkg::item_t                   q_item,
  output logic                             q_pop,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic signed [ecr_pkg::VEL_W-1:0] new_first_vel_x,
  output logic signed [ecr_pkg::VEL_W-1:0] new_first_vel_y,
  output logic signed [ecr_pkg::VEL_W-1:0] new_second_vel_x,
  output logic signed [ecr_pkg::VEL_W-1:0] new_second_vel_y,
  output logic                             coincident,
  output logic                             saturated
);

  localparam int F        = FRAC_BITS;
  localparam int VW       = ecr_pkg::VEL_W;
  localparam int DW       = ecr_pkg::DIFF_W;
  localparam int PROD_W   = 2 * DW;
  localparam int W_W      = PROD_W + 1;
  localparam int MAG_W    = PROD_W;
  localparam int HALF_W   = DW;
  localparam int PP_W     = HALF_W + DW;
  localparam int NUM1P_W  = PP_W + HALF_W;
  localparam int NUM1_W   = NUM1P_W + F;
  localparam int P_W      = F + DW;
  localparam int TWOM_W   = ecr_pkg::MASS_W + 1;
  localparam int PLO_W    = ecr_pkg::PLO_W;
  localparam int PHI_W    = P_W - PLO_W;
  localparam int PROD2_W  = P_W + TWOM_W;
  localparam int NUM2_W   = 2 * TWOM_W + 1;
  localparam int Q_W      = TWOM_W + 2;
  localparam int R_W      = VW + 4;
  localparam int SIDE_W   = $bits(ecr_pkg::side_t);
  localparam logic signed [R_W-1:0] VMAX = {{(R_W-VW+1){1'b0}}, {(VW-1){1'b1}}};
  localparam logic signed [R_W-1:0] VMIN = {{(R_W-VW+1){1'b1}}, {(VW-1){1'b0}}};

  logic adv;

  // stage 1: products
  logic                      s1_valid;
  logic signed [PROD_W-1:0]  s1_pwx, s1_pwy, s1_lx, s1_ly;
  logic [DW-1:0]             s1_anx, s1_any;
  ecr_pkg::side_t            s1_side;
  // stage 2: dot product and squared length
  logic                      s2_valid;
  logic signed [W_W-1:0]     s2_w;
  logic [MAG_W-1:0]          s2_len;
  logic [DW-1:0]             s2_anx, s2_any;
  ecr_pkg::side_t            s2_side;
  ecr_pkg::side_t            s2_side_w;
  // stage 3: magnitude of the dot product
  logic                      s3_valid;
  logic [MAG_W-1:0]          s3_wmag, s3_len;
  logic [DW-1:0]             s3_anx, s3_any;
  ecr_pkg::side_t            s3_side;
  // stage 4: partial products
  logic                      s4_valid;
  logic [PP_W-1:0]           s4_axl, s4_axh, s4_ayl, s4_ayh;
  logic [MAG_W-1:0]          s4_len;
  ecr_pkg::side_t            s4_side;
  // stage 5: projection numerators
  logic                      s5_valid;
  logic [NUM1P_W-1:0]        s5_numx, s5_numy;
  logic [MAG_W-1:0]          s5_len;
  ecr_pkg::side_t            s5_side;
  // first divider
  logic [1:0][NUM1_W-1:0]    d1_num;
  logic                      d1_valid;
  logic [1:0][P_W-1:0]       d1_quo;
  logic [SIDE_W-1:0]         d1_bits;
  ecr_pkg::side_t            d1_sd;
  logic [TWOM_W-1:0]         twom1, twom2;
  // stage 6 and 7: mass weighting
  logic                      s6_valid;
  logic [3:0][2*PLO_W-1:0]   s6_lo;
  logic [3:0][PHI_W+TWOM_W-1:0] s6_hi;
  ecr_pkg::side_t            s6_side;
  logic [3:0][PROD2_W-1:0]   s6_sum;
  logic                      s7_valid;
  logic [3:0][NUM2_W-1:0]    s7_num;
  ecr_pkg::side_t            s7_side;
  // second divider
  logic                      d2_valid;
  logic [3:0][Q_W-1:0]       d2_quo;
  logic [SIDE_W-1:0]         d2_bits;
  ecr_pkg::side_t            d2_sd;
  // stage 8: apply deltas
  logic [3:0]                neg;
  logic signed [R_W-1:0]     dlt    [4];
  logic signed [R_W-1:0]     vin    [4];
  logic signed [R_W-1:0]     r_next [4];
  logic                      s8_valid;
  logic signed [R_W-1:0]     s8_r   [4];
  logic                      s8_coin;
  // output clamp
  logic signed [VW-1:0]      vout   [4];
  logic [3:0]                clip;

  // the whole pipeline moves whenever the output slot is free or being taken
  assign adv   = !result_valid || !result_stall;
  assign q_pop = adv && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      s6_valid <= 1'b0;
      s7_valid <= 1'b0;
      s8_valid <= 1'b0;
      result_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= q_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
      s6_valid <= d1_valid;
      s7_valid <= s6_valid;
      s8_valid <= d2_valid;
      result_valid <= s8_valid;
    end
  end

  // sign of the dot product joins the side data
  always_comb begin
    s2_side_w      = s2_side;
    s2_side_w.wneg = s2_w[W_W-1];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pwx  <= q_item.dvx * q_item.nx;
      s1_pwy  <= q_item.dvy * q_item.ny;
      s1_lx   <= q_item.nx * q_item.nx;
      s1_ly   <= q_item.ny * q_item.ny;
      s1_anx  <= q_item.nx[DW-1] ? DW'(-q_item.nx) : q_item.nx;
      s1_any  <= q_item.ny[DW-1] ? DW'(-q_item.ny) : q_item.ny;
      s1_side <= q_item.side;

      s2_w    <= W_W'(s1_pwx) + W_W'(s1_pwy);
      s2_len  <= $unsigned(s1_lx) + $unsigned(s1_ly);
      s2_anx  <= s1_anx;
      s2_any  <= s1_any;
      s2_side <= s1_side;

      s3_wmag <= s2_w[W_W-1] ? MAG_W'(-s2_w) : MAG_W'(s2_w);
      s3_len  <= s2_len;
      s3_anx  <= s2_anx;
      s3_any  <= s2_any;
      s3_side <= s2_side_w;

      s4_axl  <= s3_wmag[HALF_W-1:0] * s3_anx;
      s4_axh  <= s3_wmag[MAG_W-1:HALF_W] * s3_anx;
      s4_ayl  <= s3_wmag[HALF_W-1:0] * s3_any;
      s4_ayh  <= s3_wmag[MAG_W-1:HALF_W] * s3_any;
      s4_len  <= s3_len;
      s4_side <= s3_side;

      s5_numx <= {s4_axh, {HALF_W{1'b0}}} + NUM1P_W'(s4_axl);
      s5_numy <= {s4_ayh, {HALF_W{1'b0}}} + NUM1P_W'(s4_ayl);
      s5_len  <= s4_len;
      s5_side <= s4_side;
    end
  end

  // projection quotient |w| |n_a| 2^F / |n|^2 for both axes
  assign d1_num[0] = {s5_numx, {F{1'b0}}};
  assign d1_num[1] = {s5_numy, {F{1'b0}}};

  ecr_div_pipe #(
    .NUM_W (NUM1_W),
    .DEN_W (MAG_W),
    .QUO_W (P_W),
    .LANES (2),
    .SIDE_W(SIDE_W)
  ) u_div_proj (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (s5_valid),
    .num      (d1_num),
    .den      (s5_len),
    .side_in  (s5_side),
    .out_valid(d1_valid),
    .quo      (d1_quo),
    .side_out (d1_bits)
  );

  assign d1_sd = ecr_pkg::side_t'(d1_bits);
  assign twom1 = {d1_sd.m1, 1'b0};
  assign twom2 = {d1_sd.m2, 1'b0};

  // lanes: first x, first y (other mass m2), second x, second y (other mass m1)
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        s6_lo[k] <= d1_quo[k % 2][PLO_W-1:0] * ((k < 2) ? twom2 : twom1);
        s6_hi[k] <= d1_quo[k % 2][P_W-1:PLO_W] * ((k < 2) ? twom2 : twom1);
      end
      s6_side <= d1_sd;
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      s6_sum[k] = {s6_hi[k], {PLO_W{1'b0}}} + PROD2_W'(s6_lo[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        s7_num[k] <= s6_sum[k][F +: NUM2_W];
      end
      s7_side <= s6_side;
    end
  end

  // mass weighting quotient, dividing by the mass sum after dropping 2^F
  ecr_div_pipe #(
    .NUM_W (NUM2_W),
    .DEN_W (ecr_pkg::MSUM_W),
    .QUO_W (Q_W),
    .LANES (4),
    .SIDE_W(SIDE_W)
  ) u_div_mass (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (s7_valid),
    .num      (s7_num),
    .den      (s7_side.msum),
    .side_in  (s7_side),
    .out_valid(d2_valid),
    .quo      (d2_quo),
    .side_out (d2_bits)
  );

  assign d2_sd = ecr_pkg::side_t'(d2_bits);

  assign neg[0] = d2_sd.wneg ^ d2_sd.nxneg;
  assign neg[1] = d2_sd.wneg ^ d2_sd.nyneg;
  assign neg[2] = d2_sd.wneg ^ d2_sd.nxneg;
  assign neg[3] = d2_sd.wneg ^ d2_sd.nyneg;

  always_comb begin
    vin[0] = R_W'(d2_sd.v1x);
    vin[1] = R_W'(d2_sd.v1y);
    vin[2] = R_W'(d2_sd.v2x);
    vin[3] = R_W'(d2_sd.v2y);
    for (int k = 0; k < 4; k++) begin
      dlt[k] = $signed(R_W'(d2_quo[k]));
      if (neg[k]) begin
        dlt[k] = -dlt[k];
      end
      if (d2_sd.bypass) begin
        r_next[k] = vin[k];
      end else if (k < 2) begin
        r_next[k] = vin[k] + dlt[k];
      end else begin
        r_next[k] = vin[k] - dlt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        s8_r[k] <= r_next[k];
      end
      s8_coin <= d2_sd.coin;
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      clip[k] = 1'b0;
      vout[k] = s8_r[k][VW-1:0];
      if (s8_r[k] > VMAX) begin
        clip[k] = 1'b1;
        vout[k] = VMAX[VW-1:0];
      end else if (s8_r[k] < VMIN) begin
        clip[k] = 1'b1;
        vout[k] = VMIN[VW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      new_first_vel_x  <= vout[0];
      new_first_vel_y  <= vout[1];
      new_second_vel_x <= vout[2];
      new_second_vel_y <= vout[3];
      coincident       <= s8_coin;
      saturated        <= |clip;
    end
  end

  `ECR_ASSERT_IMPL(a_coin_no_sat, clk, rst, result_valid && coincident, !saturated)
  `ECR_ASSERT_NEXT(a_pop_lands, clk, rst, q_pop, s1_valid)

endmodule

FILE: src/elastic_collision_response_2d_core.sv
// ----------------------------------------------------------------------------
// elastic_collision_response_2d_core
// two-body elastic collision in 2d, signed fixed point, one pair per cycle when not stalled
//
// input channel item_valid / item_stall carries one body pair: centres,
// velocities and masses. a word is taken on a rising edge with item_valid
// high and item_stall low. output channel result_valid / result_stall
// returns both new velocities plus the coincident and saturated flags.
// from acceptance a word passes the queue, stages 1 to 5, the projection divider
// (FRAC_BITS + 33 bit-per-stage stages), stages 6 and 7, the mass weighting
// divider (34 bit-per-stage stages), stage 8 and the output register.
// throughput is one pair per cycle while the receiver keeps taking results.
// reset clears the queue and every stage valid; data registers are not reset.
// while result_stall holds a waiting result the back pipeline freezes, the
// queue keeps taking up to QUEUE_DEPTH words, then item_stall rises.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module elastic_collision_response_2d_core #(
  parameter int FRAC_BITS   = ecr_pkg::FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH = ecr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // input channel
  input  logic                             item_valid,
  output logic                             item_stall,
  input  logic signed [ecr_pkg::POS_W-1:0] first_pos_x,
  input  logic signed [ecr_pkg::POS_W-1:0] first_pos_y,
  input  logic signed [ecr_pkg::POS_W-1:0] second_pos_x,
  input  logic signed [ecr_pkg::POS_W-1:0] second_pos_y,
  input  logic signed [ecr_pkg::VEL_W-1:0] first_vel_x,
  input  logic signed [ecr_pkg::VEL_W-1:0] first_vel_y,
  input  logic signed [ecr_pkg::VEL_W-1:0] second_vel_x,
  input  logic signed [ecr_pkg::VEL_W-1:0] second_vel_y,
  input  logic [ecr_pkg::MASS_W-1:0]       first_mass,
  input  logic [ecr_pkg::MASS_W-1:0]       second_mass,
  // output channel
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic signed [ecr_pkg::VEL_W-1:0] new_first_vel_x,
  output logic signed [ecr_pkg::VEL_W-1:0] new_first_vel_y,
  output logic signed [ecr_pkg::VEL_W-1:0] new_second_vel_x,
  output logic signed [ecr_pkg::VEL_W-1:0] new_second_vel_y,
  output logic                             coincident,
  output logic                             saturated
);

  localparam int ITEM_W = $bits(ecr_pkg::item_t);

  ecr_pkg::item_t    front_item;
  logic              q_full;
  logic              q_push;
  logic              q_pop;
  logic              q_valid;
  logic [ITEM_W-1:0] q_bits;
  ecr_pkg::item_t    q_item;

  // front: differences of centres and velocities, mass sum, special cases
  ecr_front u_front (
    .first_pos_x (first_pos_x),
    .first_pos_y (first_pos_y),
    .second_pos_x(second_pos_x),
    .second_pos_y(second_pos_y),
    .first_vel_x (first_vel_x),
    .first_vel_y (first_vel_y),
    .second_vel_x(second_vel_x),
    .second_vel_y(second_vel_y),
    .first_mass  (first_mass),
    .second_mass (second_mass),
    .item        (front_item)
  );

  // the queue decouples input acceptance from back pipeline stalls
  assign item_stall = q_full;
  assign q_push     = item_valid && !q_full;

  ecr_queue #(
    .W    (ITEM_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(front_item),
    .full     (q_full),
    .pop      (q_pop),
    .pop_valid(q_valid),
    .pop_data (q_bits)
  );

  assign q_item = ecr_pkg::item_t'(q_bits);

  // back: projection, exchange along the centre line, clamp
  ecr_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .new_first_vel_x (new_first_vel_x),
    .new_first_vel_y (new_first_vel_y),
    .new_second_vel_x(new_second_vel_x),
    .new_second_vel_y(new_second_vel_y),
    .coincident      (coincident),
    .saturated       (saturated)
  );

endmodule

FILE: tb/sv/elastic_collision_response_2d_core_tb.sv
// ----------------------------------------------------------------------------
// elastic_collision_response_2d_core_tb
// self-checking bench for the two-body collision core: a directed set of
// body pairs, then random pairs, with random input gaps and output stalls.
// a bit-exact predictor computes the expected velocities and flags per word,
// and the monitor compares each result word against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module elastic_collision_response_2d_core_tb;

  localparam int FRAC      = ecr_pkg::FRAC_BITS_DEF;
  localparam int LATENCY   = FRAC + 76;
  localparam int WDOG_MAX  = 20000;
  localparam int N_RANDOM  = 1030;

  // one body pair as driven on the input channel
  typedef struct {
    logic signed [31:0] p1x, p1y, p2x, p2y;
    logic signed [31:0] v1x, v1y, v2x, v2y;
    logic [30:0]        m1, m2;
  } pair_t;

  // one predicted result word
  typedef struct {
    logic signed [31:0] v1x, v1y, v2x, v2y;
    logic               coin, sat;
  } bounce_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               item_valid = 1'b0;
  logic               item_stall;
  logic signed [31:0] first_pos_x = '0, first_pos_y = '0;
  logic signed [31:0] second_pos_x = '0, second_pos_y = '0;
  logic signed [31:0] first_vel_x = '0, first_vel_y = '0;
  logic signed [31:0] second_vel_x = '0, second_vel_y = '0;
  logic [30:0]        first_mass = '0, second_mass = '0;
  logic               result_valid;
  logic               result_stall = 1'b1;
  logic signed [31:0] new_first_vel_x, new_first_vel_y;
  logic signed [31:0] new_second_vel_x, new_second_vel_y;
  logic               coincident, saturated;

  pair_t   pending_pairs[$];
  bounce_t expected_bounces[$];
  int      mismatch_count = 0;
  int      idle_cycles = 0;
  bit      stimulus_done = 1'b0;

  always #5 clk = ~clk;

  elastic_collision_response_2d_core dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall),
    .first_pos_x(first_pos_x), .first_pos_y(first_pos_y),
    .second_pos_x(second_pos_x), .second_pos_y(second_pos_y),
    .first_vel_x(first_vel_x), .first_vel_y(first_vel_y),
    .second_vel_x(second_vel_x), .second_vel_y(second_vel_y),
    .first_mass(first_mass), .second_mass(second_mass),
    .result_valid(result_valid), .result_stall(result_stall),
    .new_first_vel_x(new_first_vel_x), .new_first_vel_y(new_first_vel_y),
    .new_second_vel_x(new_second_vel_x), .new_second_vel_y(new_second_vel_y),
    .coincident(coincident), .saturated(saturated)
  );

  // change of the first body along one axis: sign-magnitude, truncating divides
  function automatic logic signed [127:0] axis_kick(logic [127:0] wmag, logic wneg,
      logic signed [33:0] n, logic [127:0] len2, logic [31:0] m_other,
      logic [31:0] msum);
    logic [127:0] nmag, proj, scaled;
    logic [47:0]  kick;
    nmag   = n < 0 ? 128'(-n) : 128'(n);
    proj   = ((wmag * nmag) << FRAC) / len2;
    scaled = (proj * (128'(m_other) << 1)) / (128'(msum) << FRAC);
    kick   = scaled[47:0];
    return (wneg != (n < 0)) ? -$signed({80'd0, kick}) : $signed({80'd0, kick});
  endfunction

  // clamp to the 32 bit range, raising the clip flag when it bites
  function automatic logic signed [31:0] clip32(logic signed [127:0] v, ref logic sat);
    if (v > 128'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -128'sd2147483648) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic bounce_t predict_bounce(pair_t p);
    bounce_t b;
    logic signed [33:0]  nx, ny;
    logic signed [127:0] w, r1x, r1y, r2x, r2y;
    logic [127:0]        wmag, len2;
    logic [31:0]         msum;
    logic                wneg, sat;
    nx   = 34'(p.p2x) - 34'(p.p1x);
    ny   = 34'(p.p2y) - 34'(p.p1y);
    msum = 32'(p.m1) + 32'(p.m2);
    r1x = p.v1x; r1y = p.v1y; r2x = p.v2x; r2y = p.v2y;
    sat = 1'b0;
    b.coin = (nx == 0) && (ny == 0);
    if (!b.coin && msum != 0) begin
      w    = (128'(p.v2x) - 128'(p.v1x)) * 128'(nx)
           + (128'(p.v2y) - 128'(p.v1y)) * 128'(ny);
      wneg = w < 0;
      wmag = wneg ? 128'(-w) : 128'(w);
      len2 = 128'(128'(nx) * 128'(nx)) + 128'(128'(ny) * 128'(ny));
      r1x += axis_kick(wmag, wneg, nx, len2, 32'(p.m2), msum);
      r1y += axis_kick(wmag, wneg, ny, len2, 32'(p.m2), msum);
      r2x -= axis_kick(wmag, wneg, nx, len2, 32'(p.m1), msum);
      r2y -= axis_kick(wmag, wneg, ny, len2, 32'(p.m1), msum);
    end
    b.v1x = clip32(r1x, sat);
    b.v1y = clip32(r1y, sat);
    b.v2x = clip32(r2x, sat);
    b.v2y = clip32(r2y, sat);
    b.sat = sat;
    return b;
  endfunction

  task automatic report_mismatch(string what, logic signed [31:0] got,
      logic signed [31:0] want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 255) - 128;
      3: return ($urandom_range(0, 65535) - 32768) << 8;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] rand_mass();
    case ($urandom_range(0, 4))
      0: return 31'h7fffffff;
      1: return $urandom_range(1, 16);
      2: return 31'($urandom_range(1, 1024)) << 16;
      default: return $urandom_range(1, 32'h7fffffff);
    endcase
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    p.p1x = rand_word(); p.p1y = rand_word();
    p.p2x = rand_word(); p.p2y = rand_word();
    // sometimes coincident or sharing one axis
    case ($urandom_range(0, 9))
      0: begin p.p2x = p.p1x; p.p2y = p.p1y; end
      1: p.p2x = p.p1x;
      2: p.p2y = p.p1y;
      default: ;
    endcase
    p.v1x = rand_word(); p.v1y = rand_word();
    p.v2x = rand_word(); p.v2y = rand_word();
    p.m1 = rand_mass(); p.m2 = rand_mass();
    return p;
  endfunction

  function automatic pair_t make_pair(int p1x, int p1y, int p2x, int p2y, int v1x,
      int v1y, int v2x, int v2y, logic [30:0] m1, logic [30:0] m2);
    pair_t p;
    p.p1x = p1x; p.p1y = p1y; p.p2x = p2x; p.p2y = p2y;
    p.v1x = v1x; p.v1y = v1y; p.v2x = v2x; p.v2y = v2y;
    p.m1 = m1; p.m2 = m2;
    return p;
  endfunction

  // stimulus: directed pairs, then random pairs
  initial begin
    int one;
    int maxi;
    int mini;
    one  = 32'h10000;
    maxi = 32'h7fffffff;
    mini = 32'h80000000;
    // head-on equal masses, velocities swap
    pending_pairs.push_back(make_pair(0, 0, one, 0, one, 0, -one, 0, one, one));
    // diagonal contact, unequal masses
    pending_pairs.push_back(make_pair(0, 0, one, one, 2*one, 0, 0, -one, one, 3*one));
    // coincident centres pass through
    pending_pairs.push_back(make_pair(5, 7, 5, 7, maxi, mini, 1, -1, one, one));
    pending_pairs.push_back(make_pair(mini, mini, mini, mini, mini, mini, maxi, maxi,
                                      31'h7fffffff, 31'h7fffffff));
    // extreme separations and velocities, clipping
    pending_pairs.push_back(make_pair(mini, mini, maxi, maxi, maxi, maxi, mini, mini,
                                      31'h7fffffff, 1));
    pending_pairs.push_back(make_pair(maxi, 0, mini, 0, mini, maxi, maxi, mini, 1,
                                      31'h7fffffff));
    pending_pairs.push_back(make_pair(0, 0, 1, 0, maxi, 0, mini, 0, 1, 1));
    pending_pairs.push_back(make_pair(0, 0, 0, -1, 0, mini, 0, maxi,
                                      31'h7fffffff, 31'h7fffffff));
    // tiny offset, separating bodies
    pending_pairs.push_back(make_pair(0, 0, 1, 1, -one, -one, one, one, one, one));
    // minimum masses, all-ones masses
    pending_pairs.push_back(make_pair(-3, 4, 9, -2, 100, -200, -300, 400, 1, 1));
    pending_pairs.push_back(make_pair(-1, -1, 0, 0, -1, -1, 0, 0, 31'h7fffffff, 1));
    pending_pairs.push_back(make_pair(0, 0, one, 0, 0, one, 0, -one, one, one));
    // both masses zero pass through; one mass zero takes the full exchange
    pending_pairs.push_back(make_pair(0, 0, one, 0, one, 0, -one, 0, 0, 0));
    pending_pairs.push_back(make_pair(0, 0, one, one, one, 0, -one, 0, 0, one));
    pending_pairs.push_back(make_pair(0, 0, one, one, one, 0, -one, 0, one, 0));
    repeat (N_RANDOM) pending_pairs.push_back(rand_pair());
    // a few zero-mass pairs among the noise
    repeat (5) begin
      pair_t p;
      p = rand_pair();
      p.m1 = '0;
      pending_pairs.push_back(p);
    end
    stimulus_done = 1'b1;
  end

  // reset asserted from the start and released once
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  // driver: one word at a time with a random gap before each
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      gap_left   <= $urandom_range(0, 16);
    end else if (item_valid && !item_stall) begin
      // word taken this edge: predict it, then decide on the next
      expected_bounces.push_back(predict_bounce(pending_pairs.pop_front()));
      gap_left <= $urandom_range(0, 16) * $urandom_range(0, 1);
      if (pending_pairs.size() > 0 && gap_left == 0 && $urandom_range(0, 1)) begin
        // back-to-back word keeps valid high
        first_pos_x  <= pending_pairs[0].p1x;
        first_pos_y  <= pending_pairs[0].p1y;
        second_pos_x <= pending_pairs[0].p2x;
        second_pos_y <= pending_pairs[0].p2y;
        first_vel_x  <= pending_pairs[0].v1x;
        first_vel_y  <= pending_pairs[0].v1y;
        second_vel_x <= pending_pairs[0].v2x;
        second_vel_y <= pending_pairs[0].v2y;
        first_mass   <= pending_pairs[0].m1;
        second_mass  <= pending_pairs[0].m2;
      end else begin
        item_valid <= 1'b0;
      end
    end else if (!item_valid) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (pending_pairs.size() > 0) begin
        item_valid   <= 1'b1;
        first_pos_x  <= pending_pairs[0].p1x;
        first_pos_y  <= pending_pairs[0].p1y;
        second_pos_x <= pending_pairs[0].p2x;
        second_pos_y <= pending_pairs[0].p2y;
        first_vel_x  <= pending_pairs[0].v1x;
        first_vel_y  <= pending_pairs[0].v1y;
        second_vel_x <= pending_pairs[0].v2x;
        second_vel_y <= pending_pairs[0].v2y;
        first_mass   <= pending_pairs[0].m1;
        second_mass  <= pending_pairs[0].m2;
      end
    end
  end

  // monitor: compare each taken result word, then draw a new stall length
  int stall_left = 0;
  always @(posedge clk) begin
    bounce_t want;
    int      draw;
    if (rst) begin
      result_stall <= 1'b1;
      stall_left   <= $urandom_range(0, 16);
    end else if (result_valid && !result_stall) begin
      if (expected_bounces.size() == 0) begin
        report_mismatch("unexpected word", 0, 0);
      end else begin
        want = expected_bounces.pop_front();
        if (new_first_vel_x !== want.v1x)
          report_mismatch("new_first_vel_x", new_first_vel_x, want.v1x);
        if (new_first_vel_y !== want.v1y)
          report_mismatch("new_first_vel_y", new_first_vel_y, want.v1y);
        if (new_second_vel_x !== want.v2x)
          report_mismatch("new_second_vel_x", new_second_vel_x, want.v2x);
        if (new_second_vel_y !== want.v2y)
          report_mismatch("new_second_vel_y", new_second_vel_y, want.v2y);
        if (coincident !== want.coin)
          report_mismatch("coincident", 32'(coincident), 32'(want.coin));
        if (saturated !== want.sat)
          report_mismatch("saturated", 32'(saturated), 32'(want.sat));
      end
      // at least half the words get no stall at all, for stretches at full rate
      draw = $urandom_range(0, 1) ? 0 : $urandom_range(0, 16);
      result_stall <= (draw > 0);
      stall_left   <= (draw > 0) ? draw - 1 : 0;
    end else if (stall_left > 0) begin
      result_stall <= 1'b1;
      stall_left   <= stall_left - 1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  // watchdog: cycles with no word taken on either side
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("elastic_collision_response_2d_core_tb: FAIL");
      $finish;
    end
  end

  // end of run: all words sent and answered, then a final drain
  initial begin
    wait (stimulus_done);
    @(posedge clk);
    while (pending_pairs.size() > 0 || item_valid || expected_bounces.size() > 0)
      @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
    if (mismatch_count == 0 && expected_bounces.size() == 0)
      $display("elastic_collision_response_2d_core_tb: PASS");
    else
      $display("elastic_collision_response_2d_core_tb: FAIL");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/ecr_pkg.sv
src/ecr_front.sv
src/ecr_queue.sv
src/ecr_div_pipe.sv
src/ecr_back.sv
src/elastic_collision_response_2d_core.sv
tb/sv/elastic_collision_response_2d_core_tb.sv
